>>> sv/urtb_pkg.sv
// shared types and codes for the serial port transmit/receive queues
package urtb_pkg;

  // request kinds
  typedef enum logic [1:0] {
    CMD_WRITE    = 2'd0,
    CMD_READ     = 2'd1,
    CMD_TX_EMPTY = 2'd2,
    CMD_RX_BYTE  = 2'd3
  } cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    RES_OK    = 2'd0,
    RES_FULL  = 2'd1,
    RES_EMPTY = 2'd2
  } res_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_LOAD = 2'd2
  } state_t;

  localparam int unsigned BYTE_W = 8;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic latch;
    logic load_out;
    logic tx_push;
    logic tx_pop;
    logic tx_stop;
    logic rx_push;
    logic rx_pop;
    res_t res;
    logic rvalid;
    logic lvalid;
  } ctl_t;

  // status from datapath to controller
  typedef struct packed {
    cmd_t cmd;
    logic tx_full;
    logic tx_empty;
    logic rx_full;
    logic rx_empty;
    logic out_busy;
  } sts_t;

endpackage

>>> sv/urtb_ram.sv
// generic single-write, single-read memory with registered read data
module urtb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds when idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/urtb_dp.sv
// datapath: queue pointers, byte stores, interrupt flags and result register
module urtb_dp #(
  parameter int unsigned TX_DEPTH = 64,
  parameter int unsigned RX_DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  urtb_pkg::ctl_t                 ctl,
  output urtb_pkg::sts_t                 sts,
  input  logic [1:0]                     cmd,
  input  logic [urtb_pkg::BYTE_W-1:0]    data_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     status,
  output logic [urtb_pkg::BYTE_W-1:0]    data_out,
  output logic                           read_valid,
  output logic                           line_valid,
  output logic                           tx_irq_enabled,
  output logic                           rx_available
);
  import urtb_pkg::*;

  localparam int unsigned TX_AW = $clog2(TX_DEPTH);
  localparam int unsigned RX_AW = $clog2(RX_DEPTH);
  localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);
  localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);

  cmd_t              cmd_q;
  logic [BYTE_W-1:0] data_q;

  // slot index plus wrap phase per pointer
  logic [TX_AW-1:0] tx_head;
  logic             tx_head_ph;
  logic [TX_AW-1:0] tx_tail;
  logic             tx_tail_ph;
  logic [RX_AW-1:0] rx_head;
  logic             rx_head_ph;
  logic [RX_AW-1:0] rx_tail;
  logic             rx_tail_ph;

  logic restart_mark;
  logic tx_irq_on;

  res_t pend_res;
  logic pend_rvalid;
  logic pend_lvalid;

  logic [BYTE_W-1:0] tx_rdata;
  logic [BYTE_W-1:0] rx_rdata;

  logic tx_full, tx_empty, rx_full, rx_empty;

  // fill state from pointer compare
  assign tx_empty = (tx_head == tx_tail) && (tx_head_ph == tx_tail_ph);
  assign tx_full  = (tx_head == tx_tail) && (tx_head_ph != tx_tail_ph);
  assign rx_empty = (rx_head == rx_tail) && (rx_head_ph == rx_tail_ph);
  assign rx_full  = (rx_head == rx_tail) && (rx_head_ph != rx_tail_ph);

  always_comb begin
    sts.cmd      = cmd_q;
    sts.tx_full  = tx_full;
    sts.tx_empty = tx_empty;
    sts.rx_full  = rx_full;
    sts.rx_empty = rx_empty;
    sts.out_busy = out_valid && out_stall;
  end

  // request capture
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_q  <= cmd_t'(cmd);
      data_q <= data_in;
    end
  end

  // byte stores
  urtb_ram #(.WIDTH(BYTE_W), .DEPTH(TX_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (ctl.tx_push),
    .waddr (tx_head),
    .wdata (data_q),
    .re    (ctl.tx_pop),
    .raddr (tx_tail),
    .rdata (tx_rdata)
  );

  urtb_ram #(.WIDTH(BYTE_W), .DEPTH(RX_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (ctl.rx_push),
    .waddr (rx_head),
    .wdata (data_q),
    .re    (ctl.rx_pop),
    .raddr (rx_tail),
    .rdata (rx_rdata)
  );

  // transmit pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_head    <= '0;
      tx_head_ph <= 1'b0;
      tx_tail    <= '0;
      tx_tail_ph <= 1'b0;
    end else begin
      if (ctl.tx_push) begin
        if (tx_head == TX_LAST) begin
          tx_head    <= '0;
          tx_head_ph <= ~tx_head_ph;
        end else begin
          tx_head <= tx_head + 1'b1;
        end
      end
      if (ctl.tx_pop) begin
        if (tx_tail == TX_LAST) begin
          tx_tail    <= '0;
          tx_tail_ph <= ~tx_tail_ph;
        end else begin
          tx_tail <= tx_tail + 1'b1;
        end
      end
    end
  end

  // receive pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_head    <= '0;
      rx_head_ph <= 1'b0;
      rx_tail    <= '0;
      rx_tail_ph <= 1'b0;
    end else begin
      if (ctl.rx_push) begin
        if (rx_head == RX_LAST) begin
          rx_head    <= '0;
          rx_head_ph <= ~rx_head_ph;
        end else begin
          rx_head <= rx_head + 1'b1;
        end
      end
      if (ctl.rx_pop) begin
        if (rx_tail == RX_LAST) begin
          rx_tail    <= '0;
          rx_tail_ph <= ~rx_tail_ph;
        end else begin
          rx_tail <= rx_tail + 1'b1;
        end
      end
    end
  end

  // restart mark and transmit interrupt enable
  always_ff @(posedge clk) begin
    if (rst) begin
      restart_mark <= 1'b0;
      tx_irq_on    <= 1'b1;
    end else begin
      if (ctl.tx_push && restart_mark) begin
        restart_mark <= 1'b0;
        tx_irq_on    <= 1'b1;
      end else if (ctl.tx_pop) begin
        restart_mark <= 1'b0;
      end else if (ctl.tx_stop) begin
        restart_mark <= 1'b1;
        tx_irq_on    <= 1'b0;
      end
    end
  end

  // pending result while the store read completes
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      pend_res    <= ctl.res;
      pend_rvalid <= ctl.rvalid;
      pend_lvalid <= ctl.lvalid;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      status         <= pend_res;
      read_valid     <= pend_rvalid;
      line_valid     <= pend_lvalid;
      tx_irq_enabled <= tx_irq_on;
      rx_available   <= !rx_empty;
      if (pend_rvalid) begin
        data_out <= rx_rdata;
      end else if (pend_lvalid) begin
        data_out <= tx_rdata;
      end else begin
        data_out <= '0;
      end
    end
  end

  // checks
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(read_valid && line_valid))
    else $error("read and line byte flagged together");

  a_zero_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !read_valid && !line_valid) |-> (data_out == '0))
    else $error("data_out not zero without a byte");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    !((ctl.tx_push && tx_full) || (ctl.rx_push && rx_full)))
    else $error("push into full queue");

  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    !((ctl.tx_pop && tx_empty) || (ctl.rx_pop && rx_empty)))
    else $error("pop from empty queue");

endmodule

>>> sv/urtb_ctrl.sv
// controller: request sequencing and queue command decode
module urtb_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  urtb_pkg::sts_t sts,
  output urtb_pkg::ctl_t ctl
);
  import urtb_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    ctl        = '0;
    ctl.res    = RES_OK;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.latch  = 1'b1;
        state_next = S_LOAD;
        unique case (sts.cmd)
          CMD_WRITE: begin
            if (sts.tx_full) begin
              ctl.res = RES_FULL;
            end else begin
              ctl.tx_push = 1'b1;
            end
          end
          CMD_READ: begin
            if (sts.rx_empty) begin
              ctl.res = RES_EMPTY;
            end else begin
              ctl.rx_pop = 1'b1;
              ctl.rvalid = 1'b1;
            end
          end
          CMD_TX_EMPTY: begin
            if (sts.tx_empty) begin
              ctl.tx_stop = 1'b1;
            end else begin
              ctl.tx_pop = 1'b1;
              ctl.lvalid = 1'b1;
            end
          end
          CMD_RX_BYTE: begin
            if (sts.rx_full) begin
              ctl.res = RES_FULL;
            end else begin
              ctl.rx_push = 1'b1;
            end
          end
        endcase
      end
      S_LOAD: begin
        if (!sts.out_busy) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // checks
  a_exec_follows: assert property (@(posedge clk) disable iff (rst)
    ctl.capture |=> (state == S_EXEC))
    else $error("accepted request not executed");

  a_single_queue_op: assert property (@(posedge clk) disable iff (rst)
    $countones({ctl.tx_push, ctl.tx_pop, ctl.tx_stop, ctl.rx_push, ctl.rx_pop}) <= 1)
    else $error("more than one queue operation in a step");

  a_load_held: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD && sts.out_busy) |=> (state == S_LOAD))
    else $error("result lost while output stalled");

endmodule

>>> sv/uart_tx_rx_ring_buffers_top.sv
// top level: serial port transmit and receive byte queues
//
//  channel | valid     | stall     | payload
//  in      | in_valid  | in_stall  | cmd, data_in
//  out     | out_valid | out_stall | status, data_out, read_valid, line_valid,
//          |           |           | tx_irq_enabled, rx_available
//
// a request passes through accept, queue step and result load in turn; the store
// read is registered, so the byte is taken into the read register as the pointer steps.
// a new request is accepted while the previous result still waits on out_stall;
// the result load then waits until the output register is free.
// rst is synchronous: pointers empty, restart mark clear, interrupt enable set.
// stores need no clearing pass: no read reaches an entry never written.
module uart_tx_rx_ring_buffers_top #(
  parameter int unsigned TX_DEPTH = 64,
  parameter int unsigned RX_DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  cmd,
  input  logic [urtb_pkg::BYTE_W-1:0] data_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  status,
  output logic [urtb_pkg::BYTE_W-1:0] data_out,
  output logic                        read_valid,
  output logic                        line_valid,
  output logic                        tx_irq_enabled,
  output logic                        rx_available
);
  import urtb_pkg::*;

  ctl_t ctl;
  sts_t sts;

  // sequencing
  urtb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  // queues and result register
  urtb_dp #(.TX_DEPTH(TX_DEPTH), .RX_DEPTH(RX_DEPTH)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .sts            (sts),
    .cmd            (cmd),
    .data_in        (data_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .data_out       (data_out),
    .read_valid     (read_valid),
    .line_valid     (line_valid),
    .tx_irq_enabled (tx_irq_enabled),
    .rx_available   (rx_available)
  );

endmodule
